[src/kvts_pkg.sv]
`default_nettype none

package kvts_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int VALUE_BYTES_DEF = 8;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
    localparam logic [2:0] STATUS_MISMATCH  = 3'd2;
    localparam logic [2:0] STATUS_TOO_LARGE = 3'd3;
    localparam logic [2:0] STATUS_FULL      = 3'd4;

    // keep the low nbytes bytes, up to the first zero byte
    function automatic logic [63:0] cut_key(input logic [63:0] k, input int nbytes);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < nbytes && !stop)
            begin
                if (k[8*i +: 8] == 8'h00)
                    stop = 1'b1;
                else
                    r[8*i +: 8] = k[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/kvts_cell.sv]
`default_nettype none

module kvts_cell #(
    parameter int KEY_W  = 64,
    parameter int VAL_W  = 64,
    parameter int SIZE_W = 4
) (
    input  wire logic              clk,
    input  wire logic              shift_en,
    input  wire logic              load_en,
    input  wire logic [KEY_W-1:0]  neighbor_key,
    input  wire logic [VAL_W-1:0]  neighbor_val,
    input  wire logic [SIZE_W-1:0] neighbor_size,
    input  wire logic [KEY_W-1:0]  load_key,
    input  wire logic [VAL_W-1:0]  load_val,
    input  wire logic [SIZE_W-1:0] load_size,
    output logic      [KEY_W-1:0]  key,
    output logic      [VAL_W-1:0]  val,
    output logic      [SIZE_W-1:0] size
);

    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [SIZE_W-1:0] size_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            key_reg  <= load_key;
            val_reg  <= load_val;
            size_reg <= load_size;
        end
        else if (shift_en)
        begin
            key_reg  <= neighbor_key;
            val_reg  <= neighbor_val;
            size_reg <= neighbor_size;
        end
    end

    assign key  = key_reg;
    assign val  = val_reg;
    assign size = size_reg;

endmodule

`default_nettype wire

[src/key_value_table_store.sv]
// key-value table of ENTRIES slots held in a ring of cells
//
// input channel (in_valid / in_ready) carries one request: command, lookup_key,
// write_value, value_size. output channel (out_valid / out_ready) carries one
// result per request: status, read_data, entries_used.
//
// every request rotates the ring once, slot 0 compared per cycle, with update
// or append done as the matching slot passes the head. a finish state then
// settles status and count before out_valid rises. one request is in flight
// at a time; the next is taken the cycle after the result leaves.
//
// the result holds steady while out_ready is low, and in_ready stays low
// until it is taken. reset empties the table (count to zero) and returns
// the sequencer to idle; slot contents are not cleared and never read
// before being written.
`default_nettype none

module key_value_table_store #(
    parameter int ENTRIES     = kvts_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES   = kvts_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES = kvts_pkg::VALUE_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   command,
    input  wire logic [63:0]                  lookup_key,
    input  wire logic [63:0]                  write_value,
    input  wire logic [7:0]                   value_size,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [2:0]                   status,
    output logic      [63:0]                  read_data,
    output logic      [$clog2(ENTRIES+1)-1:0] entries_used
);

    import kvts_pkg::*;

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int VAL_W  = 8 * VALUE_BYTES;
    localparam int SIZE_W = $clog2(VALUE_BYTES + 1);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_RESP   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg, found_next;
    logic             append_reg, append_next;
    logic [IDX_W-1:0] match_reg, match_next;

    logic [1:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  wval_reg;
    logic [7:0]        size_reg;
    logic [KEY_W-1:0]  hold_key_reg;
    logic [VAL_W-1:0]  hold_val_reg;
    logic [SIZE_W-1:0] hold_size_reg;
    logic [VAL_W-1:0]  rd_val_reg;
    logic [SIZE_W-1:0] rd_size_reg;
    logic [2:0]        status_reg, status_next;
    logic [63:0]       rdata_reg, rdata_next;

    logic [KEY_W-1:0]  cell_key [ENTRIES];
    logic [VAL_W-1:0]  cell_val [ENTRIES];
    logic [SIZE_W-1:0] cell_size [ENTRIES];
    logic [KEY_W-1:0]  nb_key [ENTRIES];
    logic [VAL_W-1:0]  nb_val [ENTRIES];
    logic [SIZE_W-1:0] nb_size [ENTRIES];

    logic [KEY_W-1:0]  fb_key;
    logic [VAL_W-1:0]  fb_val;
    logic [SIZE_W-1:0] fb_size;

    logic             accept;
    logic             scanning;
    logic [CNT_W-1:0] step_cnt;
    logic             occupied;
    logic             hit;
    logic             is_last;
    logic             size_ok;
    logic             wr_ok;
    logic             place;
    logic             erase_load;
    logic [63:0]      key_cut;
    logic [VAL_W-1:0] wval_masked;

    assign accept   = in_valid && in_ready;
    assign scanning = (state_reg == ST_SCAN);
    assign step_cnt = CNT_W'(step_reg);
    assign occupied = step_cnt < count_reg;
    assign hit      = occupied && (cell_key[0] == key_reg);
    assign is_last  = occupied && (step_cnt == count_reg - CNT_W'(1));
    assign size_ok  = size_reg <= 8'(VALUE_BYTES);
    assign wr_ok    = (cmd_reg == CMD_WRITE) && size_ok;
    // write lands in the head slot on a key match, or in the first free slot
    assign place    = scanning && wr_ok &&
                      (hit || (step_cnt == count_reg && !found_reg));
    assign erase_load = (state_reg == ST_FINISH) && (cmd_reg == CMD_ERASE) && found_reg;

    assign key_cut = cut_key(lookup_key, KEY_BYTES);

    always_comb
    begin
        for (int b = 0; b < VALUE_BYTES; b++)
            wval_masked[8*b +: 8] = (8'(b) < value_size) ? write_value[8*b +: 8] : 8'h00;
    end

    // head slot wraps around to the tail, possibly rewritten
    always_comb
    begin
        fb_key  = cell_key[0];
        fb_val  = cell_val[0];
        fb_size = cell_size[0];
        if (place)
        begin
            fb_key  = key_reg;
            fb_val  = wval_reg;
            fb_size = size_reg[SIZE_W-1:0];
        end
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_ring
        if (i == ENTRIES - 1)
        begin : g_tail
            assign nb_key[i]  = fb_key;
            assign nb_val[i]  = fb_val;
            assign nb_size[i] = fb_size;
        end
        else
        begin : g_body
            assign nb_key[i]  = cell_key[i+1];
            assign nb_val[i]  = cell_val[i+1];
            assign nb_size[i] = cell_size[i+1];
        end

        kvts_cell #(
            .KEY_W  (KEY_W),
            .VAL_W  (VAL_W),
            .SIZE_W (SIZE_W)
        ) u_cell (
            .clk           (clk),
            .shift_en      (scanning),
            .load_en       (erase_load && (match_reg == IDX_W'(i))),
            .neighbor_key  (nb_key[i]),
            .neighbor_val  (nb_val[i]),
            .neighbor_size (nb_size[i]),
            .load_key      (hold_key_reg),
            .load_val      (hold_val_reg),
            .load_size     (hold_size_reg),
            .key           (cell_key[i]),
            .val           (cell_val[i]),
            .size          (cell_size[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        append_next = append_reg;
        match_next  = match_reg;
        status_next = status_reg;
        rdata_next  = rdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next   = '0;
                    found_next  = 1'b0;
                    append_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    match_next = step_reg;
                end
                if (place && !hit)
                    append_next = 1'b1;
                if (step_reg == IDX_W'(ENTRIES - 1))
                begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                status_next = STATUS_OK;
                rdata_next  = '0;
                unique case (cmd_reg)
                    CMD_WRITE:
                    begin
                        if (!size_ok)
                            status_next = STATUS_TOO_LARGE;
                        else if (append_reg)
                            count_next = count_reg + CNT_W'(1);
                        else if (!found_reg)
                            status_next = STATUS_FULL;
                    end
                    CMD_READ:
                    begin
                        if (!found_reg)
                            status_next = STATUS_NOT_FOUND;
                        else if (8'(rd_size_reg) != size_reg)
                            status_next = STATUS_MISMATCH;
                        else
                            rdata_next = 64'(rd_val_reg);
                    end
                    CMD_ERASE:
                    begin
                        if (!found_reg)
                            status_next = STATUS_NOT_FOUND;
                        else
                            count_next = count_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            count_reg  <= '0;
            found_reg  <= 1'b0;
            append_reg <= 1'b0;
            match_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            found_reg  <= found_next;
            append_reg <= append_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            key_reg  <= key_cut[KEY_W-1:0];
            wval_reg <= wval_masked;
            size_reg <= value_size;
        end
        if (scanning && hit)
        begin
            rd_val_reg  <= cell_val[0];
            rd_size_reg <= cell_size[0];
        end
        // last occupied slot, moved into the gap on erase
        if (scanning && is_last)
        begin
            hold_key_reg  <= cell_key[0];
            hold_val_reg  <= cell_val[0];
            hold_size_reg <= cell_size[0];
        end
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_RESP);
    assign status       = status_reg;
    assign read_data    = rdata_reg;
    assign entries_used = count_reg;

endmodule

`default_nettype wire

[src/kvts_checker.sv]
`default_nettype none

module kvts_checker #(
    parameter int ENTRIES = kvts_pkg::ENTRIES_DEF
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [2:0]                   status,
    input wire logic [63:0]                  read_data,
    input wire logic [$clog2(ENTRIES+1)-1:0] entries_used
);

    import kvts_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_data)
            && $stable(entries_used))
        else $error("result changed while stalled");

    // one request in flight: no new request while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_NOT_FOUND
            || status == STATUS_MISMATCH || status == STATUS_TOO_LARGE
            || status == STATUS_FULL)
        else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> read_data == 64'd0)
        else $error("read data on failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_used <= CNT_W'(ENTRIES))
        else $error("entry count beyond capacity");

endmodule

bind key_value_table_store kvts_checker #(
    .ENTRIES (ENTRIES)
) u_kvts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .read_data    (read_data),
    .entries_used (entries_used)
);

`default_nettype wire

[tb/tb_key_value_table_store.sv]
`timescale 1ns / 1ps

module tb_key_value_table_store;

    import kvts_pkg::*;

    localparam int ENTRIES        = ENTRIES_DEF;
    localparam int KEY_BYTES      = KEY_BYTES_DEF;
    localparam int VALUE_BYTES    = VALUE_BYTES_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int POOL_SIZE      = 20;
    localparam int PHASE_ITEMS    = 425;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 2 * (ENTRIES + 3);

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] data;
        logic [4:0]  used;
    } kv_answer_t;

    class kv_scoreboard;
        logic [63:0] key_tab  [ENTRIES];
        logic [63:0] val_tab  [ENTRIES];
        logic [3:0]  size_tab [ENTRIES];
        int unsigned used_count;
        kv_answer_t  answers [$];
        int unsigned errors;
        int unsigned reported;

        function new();
            used_count = 0;
            errors     = 0;
            reported   = 0;
        endfunction

        function logic [63:0] lane_mask(input int unsigned n);
            if (n >= 8)
                return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        // low KEY_BYTES bytes, cut at the first zero byte
        function logic [63:0] trim_key(input logic [63:0] k);
            logic [63:0] r;
            r = '0;
            for (int i = 0; i < KEY_BYTES; i++)
            begin
                if (k[8*i +: 8] == 8'h00)
                    break;
                r[8*i +: 8] = k[8*i +: 8];
            end
            return r;
        endfunction

        function int slot_of(input logic [63:0] k);
            for (int i = 0; i < used_count; i++)
            begin
                if (key_tab[i] == k)
                    return i;
            end
            return -1;
        endfunction

        function int stored_size(input logic [63:0] raw_key);
            int slot;
            slot = slot_of(trim_key(raw_key));
            if (slot < 0)
                return -1;
            return int'(size_tab[slot]);
        endfunction

        function int pending_count();
            return answers.size();
        endfunction

        function void note_request(input logic [1:0] cmd, input logic [63:0] raw_key,
                                   input logic [63:0] wval, input logic [7:0] size);
            kv_answer_t a;
            logic [63:0] k;
            int slot;
            int unsigned last;
            a    = '0;
            k    = trim_key(raw_key);
            slot = slot_of(k);
            a.status = STATUS_OK;
            case (cmd)
                CMD_WRITE:
                begin
                    if (size > VALUE_BYTES)
                        a.status = STATUS_TOO_LARGE;
                    else if (slot < 0 && used_count >= ENTRIES)
                        a.status = STATUS_FULL;
                    else
                    begin
                        if (slot < 0)
                        begin
                            slot = used_count;
                            used_count++;
                            key_tab[slot] = k;
                        end
                        val_tab[slot]  = wval & lane_mask(size);
                        size_tab[slot] = size[3:0];
                    end
                end
                CMD_READ:
                begin
                    if (slot < 0)
                        a.status = STATUS_NOT_FOUND;
                    else if (size_tab[slot] != size)
                        a.status = STATUS_MISMATCH;
                    else
                        a.data = val_tab[slot] & lane_mask(size);
                end
                CMD_ERASE:
                begin
                    if (slot < 0)
                        a.status = STATUS_NOT_FOUND;
                    else
                    begin
                        // last entry fills the hole
                        last           = used_count - 1;
                        key_tab[slot]  = key_tab[last];
                        val_tab[slot]  = val_tab[last];
                        size_tab[slot] = size_tab[last];
                        used_count     = last;
                    end
                end
                default:
                    a.status = STATUS_OK;
            endcase
            a.used = used_count[4:0];
            answers.push_back(a);
        endfunction

        function void check_result(input logic [2:0] st, input logic [63:0] data,
                                   input logic [4:0] used);
            kv_answer_t e;
            if (answers.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result: status %0d data %h used %0d",
                             st, data, used);
                end
                return;
            end
            e = answers.pop_front();
            if (st !== e.status || data !== e.data || used !== e.used)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("mismatch: expected status %0d data %h used %0d, got %0d %h %0d",
                             e.status, e.data, e.used, st, data, used);
                end
            end
        endfunction
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  command     = '0;
    logic [63:0] lookup_key  = '0;
    logic [63:0] write_value = '0;
    logic [7:0]  value_size  = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [2:0]  status;
    logic [63:0] read_data;
    logic [$clog2(ENTRIES+1)-1:0] entries_used;

    kv_scoreboard sb = new();

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned quiet_cycles;

    logic [63:0] pool_key [POOL_SIZE];
    int unsigned pool_len [POOL_SIZE];

    key_value_table_store #(
        .ENTRIES     (ENTRIES),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .lookup_key   (lookup_key),
        .write_value  (write_value),
        .value_size   (value_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .read_data    (read_data),
        .entries_used (entries_used)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, read_data, entries_used);
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[key_value_table_store] ERROR");
        $finish;
    end

    // len nonzero bytes, a zero byte after them when len is below 8, random garbage above
    function automatic logic [63:0] make_key(input int unsigned len);
        logic [63:0] k;
        k = {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
        begin
            if (i < len)
                k[8*i +: 8] = 8'($urandom_range(1, 255));
            else if (i == len)
                k[8*i +: 8] = 8'h00;
        end
        return k;
    endfunction

    // same key, fresh garbage past its terminator
    function automatic logic [63:0] dress_key(input logic [63:0] base, input int unsigned len);
        logic [63:0] g;
        logic [63:0] m;
        g = {$urandom, $urandom};
        m = sb.lane_mask(len + 1);
        return (base & m) | (g & ~m);
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [63:0] key,
                                input logic [63:0] val, input logic [7:0] size);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        lookup_key  <= key;
        write_value <= val;
        value_size  <= size;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(cmd, key, val, size);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request(output bit counted);
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] val;
        logic [7:0]  size;
        int pick;
        int known;
        int r;
        pick = $urandom_range(POOL_SIZE - 1);
        key  = dress_key(pool_key[pick], pool_len[pick]);
        if ($urandom_range(99) < 10)
            key = {$urandom, $urandom};
        val  = {$urandom, $urandom};
        size = 8'($urandom_range(0, 8));
        if ($urandom_range(99) < 12)
            size = 8'($urandom_range(9, 255));
        r = $urandom_range(99);
        if (r < 48)
            cmd = CMD_WRITE;
        else if (r < 80)
        begin
            cmd   = CMD_READ;
            known = sb.stored_size(key);
            if (known >= 0 && $urandom_range(99) < 70)
                size = 8'(known);
        end
        else if (r < 95)
            cmd = CMD_ERASE;
        else
            cmd = CMD_UNUSED;
        counted = (cmd != CMD_UNUSED);
        send_request(cmd, key, val, size);
    endtask

    initial
    begin
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_ones;
        logic [63:0] last_key;
        int unsigned sent;
        bit counted;
        int unsigned idle_by_phase [4];
        int unsigned stall_by_phase [4];

        idle_by_phase  = '{0, 78, 0, 32};
        stall_by_phase = '{0, 0, 78, 32};
        key_a    = 64'h41;
        key_b    = 64'h00ff_ff00_0000_0042;
        key_ones = '1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then the basic cases
        send_request(CMD_READ,  key_a, '1, 8'd0);
        send_request(CMD_ERASE, key_a, '0, 8'd0);
        send_request(CMD_WRITE, key_a, {$urandom, $urandom}, 8'd0);
        send_request(CMD_READ,  key_a, '0, 8'd0);
        send_request(CMD_WRITE, key_ones, '1, 8'd8);
        send_request(CMD_READ,  key_ones, '0, 8'd8);
        send_request(CMD_READ,  key_ones, '0, 8'd4);
        send_request(CMD_WRITE, '0, {$urandom, $urandom}, 8'd8);
        // garbage after the terminator must not matter
        send_request(CMD_WRITE, key_b, {$urandom, $urandom}, 8'd3);
        send_request(CMD_READ,  64'h42, '0, 8'd3);
        send_request(CMD_WRITE, key_a, '1, 8'd255);
        send_request(CMD_UNUSED, key_ones, '1, 8'hff);

        // fill the table, then overflow it
        last_key = '0;
        while (sb.used_count < ENTRIES)
        begin
            last_key = make_key(8);
            send_request(CMD_WRITE, last_key, {$urandom, $urandom}, 8'($urandom_range(0, 8)));
        end
        send_request(CMD_WRITE, make_key(8), '1, 8'd8);
        send_request(CMD_WRITE, make_key(5), '1, 8'd200);
        send_request(CMD_ERASE, key_a, '0, 8'd0);
        send_request(CMD_READ,  last_key, '0, 8'(sb.stored_size(last_key)));
        wait_for_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_by_phase[phase];
            recv_stall_pct  = stall_by_phase[phase];
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool_len[i] = $urandom_range(0, 8);
                pool_key[i] = make_key(pool_len[i]);
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_random_request(counted);
                if (counted)
                    sent++;
            end
            // hold off until the block has answered everything
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("[key_value_table_store] OK");
        else
            $display("[key_value_table_store] ERROR");
        $finish;
    end

endmodule
